@@ hdl/hsv2rgb_pkg.sv @@
// Package for the HSV to RGB converter: item types and conversion constants.
package hsv2rgb_pkg;

	// Input item: hue in degrees, saturation and value in percent
	typedef struct packed {
		logic [8:0] hue;
		logic [6:0] saturation;
		logic [6:0] brightness;
	} hsv_item_t;

	// Result item: validity flag and 8-bit colour channels
	typedef struct packed {
		logic       in_range;
		logic [7:0] red;
		logic [7:0] green;
		logic [7:0] blue;
	} rgb_item_t;

	// Input limits
	localparam logic [8:0] HUE_MAX = 9'd359;
	localparam logic [6:0] PCT_MAX = 7'd100;
	localparam logic [7:0] FULL    = 8'd255;

	// Inclusive upper bounds of the first five hue sectors
	localparam logic [8:0] SECT0_END = 9'd60;
	localparam logic [8:0] SECT1_END = 9'd120;
	localparam logic [8:0] SECT2_END = 9'd180;
	localparam logic [8:0] SECT3_END = 9'd240;
	localparam logic [8:0] SECT4_END = 9'd300;

	// Ramp slope 425/100 reduces to 17/4
	localparam logic [4:0] RAMP_MUL   = 5'd17;
	localparam int         RAMP_SHIFT = 2;

	// x/100 as (x * 5243) >> 19, exact for x up to 25500
	localparam logic [12:0] DIV100_RECIP = 13'd5243;
	localparam int          DIV100_SHIFT = 19;

endpackage

@@ hdl/hsv_to_rgb_converter_top.sv @@
// HSV to RGB converter: five-stage pipeline, one multiplier per channel in stages 2 to 5.
// An accepted item passes through the stage 1 to stage 5 registers in order; stage 5 drives rgb.
// Throughput: one item per cycle; the pipeline stalls only when rgb_ready is low
// and a stage holding an item cannot pass it on.
// Reset (arst_n low, asynchronous) empties the pipeline by clearing all valid bits.
// Hue is decoded to sector ramps in stage 1; blend, /100, scale and /100 follow.
module hsv_to_rgb_converter_top
	import hsv2rgb_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      pix_valid,
	output logic      pix_ready,
	input  hsv_item_t pix,
	output logic      rgb_valid,
	input  logic      rgb_ready,
	output rgb_item_t rgb
);

	// Valid bits and stage advance enables
	logic vld_s1, vld_s2, vld_s3, vld_s4, vld_s5;
	logic adv1, adv2, adv3, adv4, adv5;

	assign adv5      = !vld_s5 || rgb_ready;
	assign adv4      = !vld_s4 || adv5;
	assign adv3      = !vld_s3 || adv4;
	assign adv2      = !vld_s2 || adv3;
	assign adv1      = !vld_s1 || adv2;
	assign pix_ready = adv1;
	assign rgb_valid = vld_s5;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
			vld_s5 <= 1'b0;
		end else begin
			if (adv1) vld_s1 <= pix_valid;
			if (adv2) vld_s2 <= vld_s1;
			if (adv3) vld_s3 <= vld_s2;
			if (adv4) vld_s4 <= vld_s3;
			if (adv5) vld_s5 <= vld_s4;
		end
	end

	// Stage 1: range check, sector decode and ramp
	logic            ok;
	logic [8:0]      base;
	logic [2:0]      sect;
	logic [5:0]      off;
	logic [9:0]      ramp_full;
	logic [7:0]      ramp;
	logic [7:0]      fall;
	logic [2:0][7:0] chan;

	always_comb begin
		ok = (pix.hue <= HUE_MAX) && (pix.saturation <= PCT_MAX)
			&& (pix.brightness <= PCT_MAX);
		if (pix.hue <= SECT0_END) begin
			sect = 3'd0; base = 9'd0;
		end else if (pix.hue <= SECT1_END) begin
			sect = 3'd1; base = SECT0_END;
		end else if (pix.hue <= SECT2_END) begin
			sect = 3'd2; base = SECT1_END;
		end else if (pix.hue <= SECT3_END) begin
			sect = 3'd3; base = SECT2_END;
		end else if (pix.hue <= SECT4_END) begin
			sect = 3'd4; base = SECT3_END;
		end else begin
			sect = 3'd5; base = SECT4_END;
		end
		off       = 6'(pix.hue - base);
		ramp_full = 10'(off) * 10'(RAMP_MUL);
		ramp      = ramp_full[RAMP_SHIFT +: 8];
		fall      = FULL - ramp;
		// chan[2] red, chan[1] green, chan[0] blue
		case (sect)
			3'd0:    chan = {FULL, ramp, 8'd0};
			3'd1:    chan = {fall, FULL, 8'd0};
			3'd2:    chan = {8'd0, FULL, ramp};
			3'd3:    chan = {8'd0, fall, FULL};
			3'd4:    chan = {ramp, 8'd0, FULL};
			default: chan = {FULL, 8'd0, fall};
		endcase
		// out of range: zero everything so the result comes out zero
		if (!ok) chan = '0;
	end

	logic [2:0][7:0] c_s1;
	logic [6:0]      wash_s1;
	logic [6:0]      val_s1;
	logic            ok_s1;

	always_ff @(posedge clk) begin
		if (adv1) begin
			c_s1    <= chan;
			wash_s1 <= ok ? PCT_MAX - pix.saturation : 7'd0;
			val_s1  <= ok ? pix.brightness : 7'd0;
			ok_s1   <= ok;
		end
	end

	// Stage 2: (255 - c) * wash
	logic [2:0][14:0] p_s2;
	logic [2:0][7:0]  c_s2;
	logic [6:0]       val_s2;
	logic             ok_s2;

	always_ff @(posedge clk) begin
		if (adv2) begin
			for (int i = 0; i < 3; i++) begin
				p_s2[i] <= 15'(FULL - c_s1[i]) * 15'(wash_s1);
			end
			c_s2   <= c_s1;
			val_s2 <= val_s1;
			ok_s2  <= ok_s1;
		end
	end

	// Stage 3: divide by 100 and add back the channel
	logic [2:0][27:0] q3;
	logic [2:0][7:0]  t_s3;
	logic [6:0]       val_s3;
	logic             ok_s3;

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			q3[i] = 28'(p_s2[i]) * 28'(DIV100_RECIP);
		end
	end

	always_ff @(posedge clk) begin
		if (adv3) begin
			for (int i = 0; i < 3; i++) begin
				t_s3[i] <= c_s2[i] + q3[i][DIV100_SHIFT +: 8];
			end
			val_s3 <= val_s2;
			ok_s3  <= ok_s2;
		end
	end

	// Stage 4: scale by value
	logic [2:0][14:0] m_s4;
	logic             ok_s4;

	always_ff @(posedge clk) begin
		if (adv4) begin
			for (int i = 0; i < 3; i++) begin
				m_s4[i] <= 15'(t_s3[i]) * 15'(val_s3);
			end
			ok_s4 <= ok_s3;
		end
	end

	// Stage 5: final divide by 100 into the output register
	logic [2:0][27:0] q5;
	logic [2:0][7:0]  res_s5;
	logic             ok_s5;

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			q5[i] = 28'(m_s4[i]) * 28'(DIV100_RECIP);
		end
	end

	always_ff @(posedge clk) begin
		if (adv5) begin
			for (int i = 0; i < 3; i++) begin
				res_s5[i] <= q5[i][DIV100_SHIFT +: 8];
			end
			ok_s5 <= ok_s4;
		end
	end

	assign rgb.in_range = ok_s5;
	assign rgb.red      = res_s5[2];
	assign rgb.green    = res_s5[1];
	assign rgb.blue     = res_s5[0];

endmodule
